FILE: design/fam_pkg.sv
// Shared types and constants of the binary32 add/multiply pipeline.
package fam_pkg;

	localparam int SIG_W = 57;
	localparam int MAN_W = 24;
	localparam int EXP_W = 8;
	localparam int Q_W = 10;
	localparam int BE_W = 9;

	localparam logic ACT_ADD = 1'b0;
	localparam logic ACT_MUL = 1'b1;

	localparam logic [EXP_W-1:0] EXP_MAX = 8'd255;
	localparam logic signed [Q_W-1:0] Q_ADD_OFS = 10'sd182;
	localparam logic signed [Q_W-1:0] Q_MUL_OFS = 10'sd300;
	localparam logic signed [10:0] BIAS = 11'sd127;
	localparam logic signed [10:0] SHIFT_OFS = 11'sd150;
	localparam logic [5:0] RSHIFT_CAP = 6'd57;
	localparam logic [5:0] ALIGN_CAP = 6'd56;

	typedef struct packed {
		logic action;
		logic sign_x;
		logic sign_y;
		logic signed [Q_W-1:0] q;
		logic [EXP_W-1:0] d;
		logic [MAN_W-1:0] sig_x;
		logic [MAN_W-1:0] sig_y;
		logic [2*MAN_W-1:0] prod;
	} s1_t;

	typedef struct packed {
		logic sign;
		logic zsign;
		logic signed [Q_W-1:0] q;
		logic [SIG_W-1:0] sig;
	} s2_t;

	typedef struct packed {
		logic sign;
		logic zsign;
		logic zero;
		logic [BE_W-1:0] be;
		logic left;
		logic [4:0] lamt;
		logic [5:0] ramt;
		logic [SIG_W-1:0] sig;
	} s3_t;

	typedef struct packed {
		logic [31:0] result;
		logic overflow;
		logic underflow;
	} s4_t;

endpackage

FILE: design/fam_req_if.sv
// Request channel: action and two binary32 operands.
interface fam_req_if;
	logic valid;
	logic ready;
	logic action;
	logic [31:0] operand_a;
	logic [31:0] operand_b;

	modport source (output valid, action, operand_a, operand_b, input ready);
	modport sink (input valid, action, operand_a, operand_b, output ready);
endinterface

FILE: design/fam_rsp_if.sv
// Response channel: rounded binary32 result and range flags.
interface fam_rsp_if;
	logic valid;
	logic ready;
	logic [31:0] result;
	logic overflow;
	logic underflow;

	modport source (output valid, result, overflow, underflow, input ready);
	modport sink (input valid, result, overflow, underflow, output ready);
endinterface

FILE: design/fam_prep.sv
// Stage 1 logic: unpack, order operands, exponent math and significand product.
module fam_prep import fam_pkg::*; (
	input  logic        action,
	input  logic [31:0] operand_a,
	input  logic [31:0] operand_b,
	output s1_t         s1
);
	logic [31:0] x, y;
	logic [EXP_W-1:0] ea, eb, ex, ey;
	logic [MAN_W-1:0] sa, sb, sx, sy;
	logic signed [Q_W-1:0] q_add, q_mul;

	always_comb begin
		ea = (operand_a[30:23] == '0) ? 8'd1 : operand_a[30:23];
		eb = (operand_b[30:23] == '0) ? 8'd1 : operand_b[30:23];
		sa = {operand_a[30:23] != '0, operand_a[22:0]};
		sb = {operand_b[30:23] != '0, operand_b[22:0]};
		if (operand_b[30:0] > operand_a[30:0]) begin
			x = operand_b; y = operand_a; ex = eb; ey = ea; sx = sb; sy = sa;
		end else begin
			x = operand_a; y = operand_b; ex = ea; ey = eb; sx = sa; sy = sb;
		end
		q_add = $signed({2'b00, ex}) - Q_ADD_OFS;
		q_mul = $signed({2'b00, ea}) + $signed({2'b00, eb}) - Q_MUL_OFS;
		s1.action = action;
		s1.d = ex - ey;
		s1.sig_x = sx;
		s1.sig_y = sy;
		s1.prod = sa * sb;
		if (action == ACT_MUL) begin
			s1.sign_x = operand_a[31] ^ operand_b[31];
			s1.sign_y = operand_a[31] ^ operand_b[31];
			s1.q = q_mul;
		end else begin
			s1.sign_x = x[31];
			s1.sign_y = y[31];
			s1.q = q_add;
		end
	end
endmodule

FILE: design/fam_align.sv
// Stage 2 logic: align the smaller addend with sticky, add or subtract; pass the product through for multiply.
module fam_align import fam_pkg::*; (
	input  s1_t s1,
	output s2_t s2
);
	localparam int AW = SIG_W - 1;
	logic [AW-1:0] mx, my, my_sh;
	logic [5:0] dd;
	logic lost;

	always_comb begin
		mx = {s1.sig_x, 32'b0};
		my = {s1.sig_y, 32'b0};
		dd = (s1.d >= {2'b00, ALIGN_CAP}) ? ALIGN_CAP : s1.d[5:0];
		my_sh = my >> dd;
		lost = |(my & ~({AW{1'b1}} << dd));
		my_sh = my_sh | {{(AW-1){1'b0}}, lost};
		s2.sign = s1.sign_x;
		s2.zsign = s1.sign_x & s1.sign_y;
		s2.q = s1.q;
		if (s1.action == ACT_MUL) begin
			s2.sig = {{(SIG_W-2*MAN_W){1'b0}}, s1.prod};
		end else if (s1.sign_x == s1.sign_y) begin
			s2.sig = {1'b0, mx} + {1'b0, my_sh};
		end else begin
			s2.sig = {1'b0, mx} - {1'b0, my_sh};
		end
	end
endmodule

FILE: design/fam_norm.sv
// Stage 3 logic: leading one search, biased exponent and rounding shift.
module fam_norm import fam_pkg::*; (
	input  s2_t s2,
	output s3_t s3
);
	logic [5:0] p;
	logic signed [10:0] be_raw, be, sh;

	always_comb begin
		p = '0;
		for (int i = 0; i < SIG_W; i++) begin
			if (s2.sig[i]) p = 6'(i);
		end
		be_raw = $signed({5'b0, p}) + 11'(s2.q) + BIAS;
		be = (be_raw < 11'sd1) ? 11'sd1 : be_raw;
		sh = be - SHIFT_OFS - 11'(s2.q);
		s3.sign = s2.sign;
		s3.zsign = s2.zsign;
		s3.zero = (s2.sig == '0);
		s3.be = be[BE_W-1:0];
		s3.left = sh < 11'sd0;
		s3.lamt = 5'(-sh);
		s3.ramt = (sh > $signed({5'b0, RSHIFT_CAP})) ? RSHIFT_CAP : sh[5:0];
		s3.sig = s2.sig;
	end
endmodule

FILE: design/fam_round.sv
// Stage 4 logic: shift to 24 bits, round to nearest even, pack and flag.
module fam_round import fam_pkg::*; (
	input  s3_t s3,
	output s4_t s4
);
	logic [SIG_W-1:0] shv, lowmask;
	logic [MAN_W:0] s;
	logic [BE_W:0] be;
	logic rbit, st;

	always_comb begin
		lowmask = ~({SIG_W{1'b1}} << s3.ramt);
		if (s3.left) begin
			shv = s3.sig << s3.lamt;
			rbit = 1'b0;
			st = 1'b0;
		end else begin
			shv = s3.sig >> s3.ramt;
			rbit = (s3.ramt != '0) && s3.sig[s3.ramt - 6'd1];
			st = |(s3.sig & (lowmask >> 1));
		end
		s = {1'b0, shv[MAN_W-1:0]};
		be = {1'b0, s3.be};
		if (rbit && (st || s[0])) s = s + 1'b1;
		if (s[MAN_W]) begin
			s = s >> 1;
			be = be + 1'b1;
		end
		s4.overflow = 1'b0;
		s4.underflow = 1'b0;
		if (s3.zero) begin
			s4.result = {s3.zsign, 31'b0};
		end else if (be >= {2'b00, EXP_MAX}) begin
			s4.overflow = 1'b1;
			s4.result = {s3.sign, EXP_MAX, 23'b0};
		end else if (s == '0) begin
			s4.underflow = 1'b1;
			s4.result = {s3.sign, 31'b0};
		end else begin
			s4.result = {s3.sign, (s[MAN_W-1] ? be[EXP_W-1:0] : 8'd0), s[22:0]};
		end
	end
endmodule

FILE: design/float32_add_multiply_unit.sv
// Top level: four-stage binary32 add/multiply pipeline.
// Usage:
//   op  : request channel (valid/ready) carrying action (0 add, 1 multiply),
//         operand_a and operand_b as binary32 bit patterns.
//   res : response channel (valid/ready) carrying the rounded result and the
//         overflow and underflow flags; one response per request, in order.
// A request passes in order through stage registers d_s1 to d_s4 and is
// shown on res once in d_s4. Throughput is one request per cycle while
// res.ready is high; the four register stages are unpack and multiply,
// align and add, leading-one search, then round and pack.
// Each stage advances when it is empty or its successor advances, so bubbles
// close up and a stalled receiver back-pressures op.ready only when all four
// stages hold requests. Nothing is dropped or repeated during a stall.
// Infinity and NaN encodings are treated as ordinary finite numbers.
// Reset clears all stage valid bits; the pipeline is empty afterwards and
// accepts a request in the first cycle after reset is released.
module float32_add_multiply_unit import fam_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	fam_req_if.sink      op,
	fam_rsp_if.source    res
);
	s1_t c1, d_s1;
	s2_t c2, d_s2;
	s3_t c3, d_s3;
	s4_t c4, d_s4;
	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;

	fam_prep u_prep (
		.action(op.action), .operand_a(op.operand_a), .operand_b(op.operand_b), .s1(c1)
	);
	fam_align u_align (.s1(d_s1), .s2(c2));
	fam_norm u_norm (.s2(d_s2), .s3(c3));
	fam_round u_round (.s3(d_s3), .s4(c4));

	assign en4 = !v_s4 || res.ready;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign op.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= op.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) d_s1 <= c1;
		if (en2) d_s2 <= c2;
		if (en3) d_s3 <= c3;
		if (en4) d_s4 <= c4;
	end

	assign res.valid = v_s4;
	assign res.result = d_s4.result;
	assign res.overflow = d_s4.overflow;
	assign res.underflow = d_s4.underflow;

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> !(res.overflow && res.underflow))
		else $error("overflow and underflow both set");

	a_ovf_inf: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.overflow) |-> (res.result[30:0] == 31'h7F800000))
		else $error("overflow without infinity");

	a_unf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.underflow) |-> (res.result[30:0] == 31'h0))
		else $error("underflow without zero");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && v_s2 && v_s3 && v_s4 && !res.ready) |-> !op.ready)
		else $error("request taken while pipeline full and stalled");
endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the binary32 add/multiply pipeline.
module testbench;
	import fam_pkg::*;

	typedef struct packed {
		logic action;
		logic [31:0] a;
		logic [31:0] b;
	} fp_req_t;

	typedef struct packed {
		logic [31:0] value;
		logic over;
		logic under;
	} fp_rsp_t;

	logic clk;
	logic arst_n;
	fam_req_if op();
	fam_rsp_if res();

	float32_add_multiply_unit u_top (.clk(clk), .arst_n(arst_n), .op(op), .res(res));

	fp_req_t pending_reqs[$];
	fp_rsp_t expected_rsps[$];
	int errors = 0;
	bit hold_sink = 0;
	bit calm_src = 0;
	bit calm_sink = 0;
	bit src_pause = 0;

	initial clk = 0;
	always #5 clk = ~clk;

	function automatic logic [63:0] sig_of(logic [31:0] v);
		return {40'd0, (v[30:23] != 0), v[22:0]};
	endfunction

	function automatic int eff_exp_of(logic [31:0] v);
		return (v[30:23] != 0) ? int'(v[30:23]) : 1;
	endfunction

	function automatic fp_rsp_t round_to_single(logic sign, int q, logic [63:0] sig);
		fp_rsp_t r;
		int p, be, sh;
		logic [63:0] s;
		logic rbit, st;
		r = '0;
		p = 63;
		while (!sig[p]) p--;
		be = p + q + 127;
		if (be < 1) be = 1;
		sh = be - 150 - q;
		if (sh <= 0) begin
			s = sig << (-sh);
			rbit = 0;
			st = 0;
		end else if (sh <= 63) begin
			s = sig >> sh;
			rbit = sig[sh-1];
			st = (sig & ((64'd1 << (sh - 1)) - 1)) != 0;
		end else if (sh == 64) begin
			s = 0;
			rbit = sig[63];
			st = sig[62:0] != 0;
		end else begin
			s = 0;
			rbit = 0;
			st = 1;
		end
		if (rbit && (st || s[0])) s++;
		if (s[63:24] != 0) begin
			s = s >> 1;
			be++;
		end
		if (be >= 255) begin
			r.value = {sign, 31'h7F800000};
			r.over = 1;
		end else if (s == 0) begin
			r.value = {sign, 31'd0};
			r.under = 1;
		end else begin
			r.value = {sign, (s >= 64'h800000) ? be[7:0] : 8'd0, s[22:0]};
		end
		return r;
	endfunction

	function automatic fp_rsp_t predict_result(fp_req_t rq);
		fp_rsp_t r;
		logic [31:0] x, y;
		logic [63:0] mx, my, total, lost;
		int d;
		r = '0;
		if (rq.action == ACT_MUL) begin
			total = sig_of(rq.a) * sig_of(rq.b);
			if (total == 0) r.value = {rq.a[31] ^ rq.b[31], 31'd0};
			else r = round_to_single(rq.a[31] ^ rq.b[31],
				eff_exp_of(rq.a) + eff_exp_of(rq.b) - 300, total);
		end else begin
			x = rq.a;
			y = rq.b;
			if (rq.b[30:0] > rq.a[30:0]) begin
				x = rq.b;
				y = rq.a;
			end
			d = eff_exp_of(x) - eff_exp_of(y);
			mx = sig_of(x) << 32;
			my = sig_of(y) << 32;
			if (d >= 64) begin
				my = (my != 0);
			end else if (d > 0) begin
				lost = my & ((64'd1 << d) - 1);
				my = (my >> d) | (lost != 0);
			end
			total = (x[31] == y[31]) ? mx + my : mx - my;
			if (total == 0) r.value = {x[31] & y[31], 31'd0};
			else r = round_to_single(x[31], eff_exp_of(x) - 182, total);
		end
		return r;
	endfunction

	function automatic logic [31:0] rand_float();
		logic [31:0] v;
		int unsigned k;
		v = $urandom;
		k = $urandom_range(0, 9);
		if (k == 0) v[30:23] = 0;
		else if (k == 1) v[30:23] = $urandom_range(250, 255);
		else if (k == 2) v[30:23] = $urandom_range(0, 5);
		else if (k == 3) v[22:0] = $urandom_range(0, 1) ? 23'd0 : 23'h7FFFFF;
		else if (k == 4) v[30:0] = 0;
		return v;
	endfunction

	function automatic void push_req(logic act, logic [31:0] a, logic [31:0] b);
		fp_req_t rq;
		rq.action = act;
		rq.a = a;
		rq.b = b;
		pending_reqs.push_back(rq);
	endfunction

	// Request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op.valid <= 0;
			op.action <= 0;
			op.operand_a <= 0;
			op.operand_b <= 0;
		end else begin
			if (op.valid && op.ready) begin
				expected_rsps.push_back(predict_result({op.action, op.operand_a, op.operand_b}));
				void'(pending_reqs.pop_front());
			end
			if (pending_reqs.size() > 0 && !src_pause
					&& (calm_src || $urandom_range(0, 99) >= 25)) begin
				op.valid <= 1;
				op.action <= pending_reqs[0].action;
				op.operand_a <= pending_reqs[0].a;
				op.operand_b <= pending_reqs[0].b;
			end else if (!(op.valid && !op.ready)) begin
				op.valid <= 0;
			end
		end
	end

	// Response monitor
	always @(posedge clk or negedge arst_n) begin
		fp_rsp_t want;
		if (!arst_n) begin
			res.ready <= 0;
		end else begin
			if (res.valid && res.ready) begin
				if (expected_rsps.size() == 0) begin
					$display("%0t: unexpected response %h", $time, res.result);
					errors++;
				end else begin
					want = expected_rsps.pop_front();
					if (res.result !== want.value)
						$display("%0t: result expected %h actual %h", $time, want.value,
							res.result);
					if (res.overflow !== want.over)
						$display("%0t: overflow expected %b actual %b", $time, want.over,
							res.overflow);
					if (res.underflow !== want.under)
						$display("%0t: underflow expected %b actual %b", $time, want.under,
							res.underflow);
					if (res.result !== want.value || res.overflow !== want.over
							|| res.underflow !== want.under)
						errors++;
				end
			end
			res.ready <= !hold_sink && (calm_sink || $urandom_range(0, 99) >= 25);
		end
	end

	// Hold the receiver off so the pipeline fills and stalls the request side
	initial begin
		wait (arst_n);
		repeat (300) @(posedge clk);
		hold_sink = 1;
		repeat (40) @(posedge clk);
		hold_sink = 0;
	end

	initial begin
		int i;
		arst_n = 0;
		for (i = 0; i < 2; i++) begin
			push_req(i, 32'h0000_0000, 32'h8000_0000);
			push_req(i, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
			push_req(i, 32'hFFFF_FFFF, 32'h7F80_0000);
			push_req(i, 32'h0000_0001, 32'h8000_0001);
			push_req(i, 32'h8000_0001, 32'h8000_0001);
			push_req(i, 32'h007F_FFFF, 32'h0000_0001);
			push_req(i, 32'h3F80_0000, 32'hBF80_0000);
			push_req(i, 32'hBF80_0000, 32'hBF80_0000);
			push_req(i, 32'h7F7F_FFFF, 32'h7F7F_FFFF);
			push_req(i, 32'h0080_0000, 32'h3E80_0000);
			push_req(i, 32'h3F80_0000, 32'h3380_0000);
			push_req(i, 32'h4B80_0000, 32'hB3FF_FFFF);
		end
		repeat (9) @(posedge clk);
		arst_n <= 1;
		for (i = 0; i < 1950; i++) push_req($urandom_range(0, 1), rand_float(), rand_float());
		// Calm stretch for full-rate traffic
		wait (pending_reqs.size() < 1400);
		calm_src = 1;
		calm_sink = 1;
		wait (pending_reqs.size() < 1100);
		calm_src = 0;
		calm_sink = 0;
		// Pause the sender until the pipeline drains
		src_pause = 1;
		wait (expected_rsps.size() == 0 && !op.valid);
		repeat (8) @(posedge clk);
		src_pause = 0;
		wait (pending_reqs.size() == 0);
		@(posedge clk);
		wait (expected_rsps.size() == 0);
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

	initial begin
		#400000;
		$display("testbench: errors");
		$finish;
	end
endmodule

FILE: files.f
design/fam_pkg.sv
design/fam_req_if.sv
design/fam_rsp_if.sv
design/fam_prep.sv
design/fam_align.sv
design/fam_norm.sv
design/fam_round.sv
design/float32_add_multiply_unit.sv
tb/sv/testbench.sv
